>>> rtl/bcd_record_to_ascii_lister_assert.svh
// Assertion macros shared by the lister modules.
// Every macro samples on clock and is disabled while reset is high.
`ifndef BCD_RECORD_TO_ASCII_LISTER_ASSERT_SVH
`define BCD_RECORD_TO_ASCII_LISTER_ASSERT_SVH

// expr holds at every edge
`define BRTAL_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("brtal: invariant violated");

// cons holds in the same cycle as ante
`define BRTAL_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("brtal: implication violated");

// cons holds in the cycle after ante
`define BRTAL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("brtal: next-cycle check violated");

`endif

>>> rtl/brtal_pkg.sv
package brtal_pkg;

   typedef struct packed {
      logic       action;
      logic [7:0] tape_char;
      logic       record_end;
   } req_type;

   typedef struct packed {
      logic [6:0] ascii_char;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [9:0] record_length;
      logic       binary_mode;
      logic       show_marks;
      logic       show_end_marker;
   } cfg_type;

   // One classified item: what the back end has to emit for it.
   typedef struct packed {
      logic       is_eof;
      logic [6:0] first_char;
      logic       has_break;
      logic       has_brace;
      logic       has_end;
   } job_type;

   localparam logic [1:0] CSR_RECORD_LENGTH   = 2'd0;
   localparam logic [1:0] CSR_BINARY_MODE     = 2'd1;
   localparam logic [1:0] CSR_SHOW_MARKS      = 2'd2;
   localparam logic [1:0] CSR_SHOW_END_MARKER = 2'd3;

   localparam logic [9:0]  RECORD_LENGTH_RESET = 10'd130;
   localparam logic [10:0] COL_MAX             = 11'd2047;

   localparam logic [5:0] CODE_RECORD_MARK = 6'o32;
   localparam logic [5:0] CODE_BIN_ZERO    = 6'o12;

   localparam logic [6:0] ASCII_NL    = 7'h0A;
   localparam logic [6:0] ASCII_BRACE = 7'h7B;

   localparam logic [2:0] EOF_LEN = 3'd6;

   localparam logic [6:0] BCD_TABLE [0:63] = '{
      7'h62, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h30, 7'h3D, 7'h27, 7'h3A, 7'h3E, 7'h26,
      7'h20, 7'h2F, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
      7'h59, 7'h5A, 7'h7C, 7'h2C, 7'h28, 7'h7E, 7'h5C, 7'h22,
      7'h2D, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50,
      7'h51, 7'h52, 7'h21, 7'h24, 7'h2A, 7'h5D, 7'h3B, 7'h5F,
      7'h2B, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
      7'h48, 7'h49, 7'h3F, 7'h2E, 7'h29, 7'h5B, 7'h3C, 7'h7D
   };

   function automatic logic [6:0] bcd_to_ascii(input logic [5:0] code);
      return BCD_TABLE[code];
   endfunction

   // "*EOF*" then newline
   function automatic logic [6:0] eof_char(input logic [2:0] step);
      logic [6:0] ch;
      case (step)
         3'd0:    ch = 7'h2A;
         3'd1:    ch = 7'h45;
         3'd2:    ch = 7'h4F;
         3'd3:    ch = 7'h46;
         3'd4:    ch = 7'h2A;
         default: ch = ASCII_NL;
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/brtal_front.sv
module brtal_front import brtal_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   input  logic    queue_full,
   output logic    push,
   output job_type push_job
);

   logic [10:0] column_ff;
   logic [10:0] column_in;
   logic [10:0] column_adv;
   logic [5:0]  code;
   logic        is_mark;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      code = req_data.tape_char[5:0];
      if (cfg.binary_mode) begin
         code[5] = code[5] ^ code[4];
         if (code == CODE_BIN_ZERO) begin
            code = 6'd0;
         end
      end
      is_mark    = (code == CODE_RECORD_MARK);
      column_adv = (column_ff == COL_MAX) ? column_ff : column_ff + 11'd1;

      push_job  = '0;
      column_in = column_ff;
      if (req_data.action) begin
         push_job.is_eof = 1'b1;
         column_in       = '0;
      end else begin
         if (is_mark && !cfg.show_marks) begin
            push_job.first_char = ASCII_NL;
            column_in           = '0;
         end else begin
            push_job.first_char = bcd_to_ascii(code);
            column_in           = column_adv;
            push_job.has_break  = !is_mark && !req_data.record_end
                                  && (column_adv == {1'b0, cfg.record_length});
            if (push_job.has_break) begin
               column_in = '0;
            end
         end
         if (req_data.record_end) begin
            push_job.has_end   = 1'b1;
            push_job.has_brace = cfg.show_end_marker;
            column_in          = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else if (push) begin
         column_ff <= column_in;
      end
   end

endmodule

>>> rtl/brtal_queue.sv
`include "bcd_record_to_ascii_lister_assert.svh"

module brtal_queue import brtal_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   `BRTAL_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH))
   `BRTAL_ASSERT_NEXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))
   `BRTAL_ASSERT_IMPLY(a_empty_aligned, count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

>>> rtl/brtal_back.sv
`include "bcd_record_to_ascii_lister_assert.svh"

module brtal_back import brtal_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic [2:0] step_ff;
   logic [2:0] step_in;
   logic [2:0] total;
   logic       final_step;
   logic       load;
   logic [6:0] ch;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   always_comb begin
      if (head_job.is_eof) begin
         total = EOF_LEN;
         ch    = eof_char(step_ff);
      end else begin
         total = 3'd1 + {2'b0, head_job.has_break} + {2'b0, head_job.has_brace}
                 + {2'b0, head_job.has_end};
         // tail is a break newline, an end newline, or brace then newline
         case (step_ff)
            3'd0:    ch = head_job.first_char;
            3'd1:    ch = head_job.has_brace ? ASCII_BRACE : ASCII_NL;
            default: ch = ASCII_NL;
         endcase
      end
      final_step = (step_ff == total - 3'd1);
      load       = head_valid && (!rsp_valid_ff || !rsp_stall);
      pop        = load && final_step;
      step_in    = final_step ? 3'd0 : step_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         step_ff      <= step_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.ascii_char  <= ch;
         rsp_data_ff.last_of_run <= final_step;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BRTAL_ASSERT_ALWAYS(a_step_bound, step_ff < EOF_LEN)
   `BRTAL_ASSERT_IMPLY(a_mid_job_has_head, step_ff != 3'd0, head_valid)
   `BRTAL_ASSERT_NEXT(a_pop_marks_last, pop, rsp_valid_ff && rsp_data_ff.last_of_run)

endmodule

>>> rtl/bcd_record_to_ascii_lister.sv
// A transfer on req is written into the job queue; its first result is then registered
// at rsp. Throughput: one req transfer per cycle while the job queue has room; the
// result port sends one character per cycle while rsp_stall is low and a job is queued, and the single
// emit sequencer gives an item 1 to 3 characters (record character) or 6 (tape mark).
// Reset (synchronous, active high) clears the column, the queue, the output valid flag
// and emit step, and restores every configuration register to its documented default.
module bcd_record_to_ascii_lister import brtal_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  brtal_pkg::req_type  req_data,
   output logic                req_stall,
   output logic                rsp_valid,
   output brtal_pkg::rsp_type  rsp_data,
   input  logic                rsp_stall,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [9:0]          csr_wdata
);

   cfg_type cfg_ff;
   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // Configuration: always ready; software writes only while the lister is idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.record_length   <= RECORD_LENGTH_RESET;
         cfg_ff.binary_mode     <= 1'b0;
         cfg_ff.show_marks      <= 1'b0;
         cfg_ff.show_end_marker <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RECORD_LENGTH:   cfg_ff.record_length   <= csr_wdata;
            CSR_BINARY_MODE:     cfg_ff.binary_mode     <= csr_wdata[0];
            CSR_SHOW_MARKS:      cfg_ff.show_marks      <= csr_wdata[0];
            CSR_SHOW_END_MARKER: cfg_ff.show_end_marker <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Front: translate the tape code, track the column, and decide which
   // line breaks, braces and newlines follow each character.
   brtal_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Job queue: decouples input acceptance from the multi-character output.
   brtal_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back: step through the characters of the head job, one transfer per cycle while rsp_stall
   // is low, and flag the final one of each item.
   brtal_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule
